// ===== hw/rtl/format_string_integer_printer_assert.svh =====
// Assertion macros used by the formatter back end.
`ifndef FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH
`define FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FSIP_ASSERT_HOLDS(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("fsip: assertion failed");

// Next-cycle implication, disabled while in reset.
`define FSIP_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("fsip: assertion failed");

`endif

// ===== hw/rtl/fsip_pkg.sv =====
// Types, constants and helper functions shared by the formatter modules.
`timescale 1ns / 1ps
package fsip_pkg;

  localparam int ARG_FIELD_W       = 32;
  localparam int DEFAULT_ARG_WIDTH = 32;
  localparam int CHAR_W            = 8;
  localparam int LEN_W             = 16;
  localparam int POS_W             = 4;
  localparam int WIDE_W            = 36;
  localparam int DEC_MAX_POS       = 9;
  localparam int FIFO_DEPTH        = 2;

  localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT  = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_HEX_BASE = 8'h37;  // 'A' minus ten
  localparam logic [CHAR_W-1:0] CH_C        = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D        = 8'h64;
  localparam logic [CHAR_W-1:0] CH_L        = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_X        = 8'h78;

  typedef enum logic [1:0] {
    K_NUL  = 2'd0,
    K_TEXT = 2'd1,
    K_DEC  = 2'd2,
    K_HEX  = 2'd3
  } kind_t;

  // One queued command; the numeric argument travels beside it.
  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic              dual;
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c1;
  } fsip_cmd_t;

  function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] k);
    logic [WIDE_W-1:0] p;
    case (k)
      4'd0:    p = 36'd1;
      4'd1:    p = 36'd10;
      4'd2:    p = 36'd100;
      4'd3:    p = 36'd1000;
      4'd4:    p = 36'd10000;
      4'd5:    p = 36'd100000;
      4'd6:    p = 36'd1000000;
      4'd7:    p = 36'd10000000;
      4'd8:    p = 36'd100000000;
      4'd9:    p = 36'd1000000000;
      4'd10:   p = 36'd10000000000;
      default: p = 36'd0;
    endcase
    return p;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
    logic [CHAR_W-1:0] ch;
    if (n < 4'd10) begin
      ch = CH_ZERO + {4'h0, n};
    end else begin
      ch = CH_HEX_BASE + {4'h0, n};
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/fsip_front.sv =====
// Front end: accepts format bytes, tracks a pending percent, queues commands.
`timescale 1ns / 1ps
module fsip_front #(
  parameter int ARG_WIDTH = fsip_pkg::DEFAULT_ARG_WIDTH,
  localparam int VAL_W = (ARG_WIDTH < fsip_pkg::ARG_FIELD_W) ? ARG_WIDTH
                                                              : fsip_pkg::ARG_FIELD_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fmt_valid,
  output logic                               fmt_ready,
  input  logic [fsip_pkg::CHAR_W-1:0]        fmt_char,
  input  logic [fsip_pkg::ARG_FIELD_W-1:0]   arg_value,
  input  logic                               full,
  output logic                               push,
  output fsip_pkg::fsip_cmd_t                push_cmd,
  output logic [VAL_W-1:0]                   push_val
);
  import fsip_pkg::*;

  // The sign bit lies inside the argument field only up to its width.
  localparam bit SIGNED_ARG = (ARG_WIDTH <= ARG_FIELD_W);

  logic             percent_pending;
  logic             percent_pending_next;
  logic             accept;
  logic             produce;
  logic [VAL_W-1:0] val_masked;
  logic             negative;

  assign fmt_ready = !full;
  assign accept    = fmt_valid && fmt_ready;
  assign push      = accept && produce;

  always_comb begin
    val_masked           = arg_value[VAL_W-1:0];
    negative             = SIGNED_ARG && val_masked[VAL_W-1];
    produce              = 1'b1;
    percent_pending_next = percent_pending;
    push_val             = val_masked;
    push_cmd.kind        = K_TEXT;
    push_cmd.neg         = 1'b0;
    push_cmd.dual        = 1'b0;
    push_cmd.c0          = fmt_char;
    push_cmd.c1          = fmt_char;
    if (fmt_char == CH_NUL) begin
      push_cmd.kind        = K_NUL;
      percent_pending_next = 1'b0;
    end else if (!percent_pending) begin
      if (fmt_char == CH_PERCENT) begin
        produce              = 1'b0;
        percent_pending_next = 1'b1;
      end
    end else begin
      percent_pending_next = 1'b0;
      unique case (fmt_char)
        CH_D: begin
          push_cmd.kind = K_DEC;
          push_cmd.neg  = negative;
          if (negative) begin
            push_val = (~val_masked) + VAL_W'(1);
          end
        end
        CH_L: push_cmd.kind = K_DEC;
        CH_X: push_cmd.kind = K_HEX;
        CH_C: push_cmd.c0 = val_masked[CHAR_W-1:0];
        CH_PERCENT: push_cmd.c0 = CH_PERCENT;
        default: begin
          // unknown sequence: percent, then the byte itself
          push_cmd.dual = 1'b1;
          push_cmd.c0   = CH_PERCENT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
    end else if (accept) begin
      percent_pending <= percent_pending_next;
    end
  end

endmodule

// ===== hw/rtl/fsip_queue.sv =====
// Short command queue between the front end and the character emitter.
`timescale 1ns / 1ps
module fsip_queue #(
  parameter int ARG_WIDTH = fsip_pkg::DEFAULT_ARG_WIDTH,
  localparam int VAL_W = (ARG_WIDTH < fsip_pkg::ARG_FIELD_W) ? ARG_WIDTH
                                                              : fsip_pkg::ARG_FIELD_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fsip_pkg::fsip_cmd_t  push_cmd,
  input  logic [VAL_W-1:0]     push_val,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output fsip_pkg::fsip_cmd_t  head_cmd,
  output logic [VAL_W-1:0]     head_val
);
  import fsip_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  fsip_cmd_t        cmd_mem [FIFO_DEPTH];
  logic [VAL_W-1:0] val_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = cmd_mem[rd_ptr];
  assign head_val = val_mem[rd_ptr];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr] <= push_cmd;
      val_mem[wr_ptr] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/fsip_back.sv =====
// Back end: expands one queued command into text beats, one per cycle while the output is not stalled.
`timescale 1ns / 1ps
module fsip_back #(
  parameter int ARG_WIDTH = fsip_pkg::DEFAULT_ARG_WIDTH,
  localparam int VAL_W = (ARG_WIDTH < fsip_pkg::ARG_FIELD_W) ? ARG_WIDTH
                                                              : fsip_pkg::ARG_FIELD_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  fsip_pkg::fsip_cmd_t           head_cmd,
  input  logic [VAL_W-1:0]              head_val,
  output logic                          pop,
  output logic                          txt_valid,
  input  logic                          txt_ready,
  output logic [fsip_pkg::CHAR_W-1:0]   out_char,
  output logic                          last_of_run,
  output logic [fsip_pkg::LEN_W-1:0]    text_length
);
  import fsip_pkg::*;

  localparam int HEX_N     = (VAL_W + 3) / 4;
  localparam int HEX_W     = HEX_N * 4;
  localparam int NIB_IDX_W = $clog2(HEX_N);
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t            state;
  kind_t             kind;
  logic              neg_pending;
  logic              dual;
  logic [CHAR_W-1:0] c0;
  logic [CHAR_W-1:0] c1;
  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  val;
  logic [LEN_W-1:0]  emitted_count;

  logic              advance_out;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic [POS_W-1:0]  load_pos;
  logic [HEX_W-1:0]  head_pad;
  logic [WIDE_W-1:0] head_ext;
  logic [HEX_W-1:0]  val_pad;
  logic [3:0]        nib [HEX_N];
  logic [WIDE_W-1:0] val_ext;
  logic [WIDE_W-1:0] place;
  logic [3:0]        dig;
  logic [WIDE_W-1:0] remainder;

  assign advance_out = !txt_valid || txt_ready;
  assign emit        = (state == ST_EMIT) && advance_out;
  assign pop         = (state == ST_IDLE) && !empty;

  // Starting digit position: decade or nibble of the leading digit.
  always_comb begin
    head_pad = HEX_W'(head_val);
    head_ext = WIDE_W'(head_val);
    load_pos = '0;
    if (head_cmd.kind == K_DEC) begin
      for (int k = 1; k <= DEC_MAX_POS; k++) begin
        if (head_ext >= pow10(POS_W'(k))) begin
          load_pos = POS_W'(k);
        end
      end
    end else if (head_cmd.kind == K_HEX) begin
      for (int k = 0; k < HEX_N; k++) begin
        if (head_pad[k*4 +: 4] != 4'h0) begin
          load_pos = POS_W'(k);
        end
      end
    end
  end

  // Decimal digit at the current decade: count multiples of the place value.
  always_comb begin
    val_pad = HEX_W'(val);
    for (int k = 0; k < HEX_N; k++) begin
      nib[k] = val_pad[k*4 +: 4];
    end
    val_ext = WIDE_W'(val);
    place   = pow10(pos);
    dig     = 4'd0;
    for (int m = 1; m <= 9; m++) begin
      if (val_ext >= WIDE_W'(m) * place) begin
        dig = 4'(m);
      end
    end
    remainder = val_ext - WIDE_W'(dig) * place;
  end

  always_comb begin
    emit_char = c0;
    emit_last = 1'b1;
    case (kind)
      K_NUL: begin
        emit_char = CH_NUL;
        emit_last = 1'b1;
      end
      K_TEXT: begin
        emit_char = c0;
        emit_last = !dual;
      end
      K_DEC: begin
        if (neg_pending) begin
          emit_char = CH_MINUS;
          emit_last = 1'b0;
        end else begin
          emit_char = CH_ZERO + {4'h0, dig};
          emit_last = (pos == '0);
        end
      end
      K_HEX: begin
        emit_char = hex_char(nib[pos[NIB_IDX_W-1:0]]);
        emit_last = (pos == '0);
      end
      default: begin
        emit_char = c0;
        emit_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind        <= head_cmd.kind;
      neg_pending <= head_cmd.neg;
      dual        <= head_cmd.dual;
      c0          <= head_cmd.c0;
      c1          <= head_cmd.c1;
      pos         <= load_pos;
      val         <= head_val;
    end else if (emit) begin
      if (kind == K_TEXT && dual) begin
        c0   <= c1;
        dual <= 1'b0;
      end
      if (kind == K_DEC && neg_pending) begin
        neg_pending <= 1'b0;
      end else if (kind == K_DEC || kind == K_HEX) begin
        pos <= pos - POS_W'(1);
        if (kind == K_DEC) begin
          val <= remainder[VAL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      emitted_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit && emit_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (emit) begin
        if (kind == K_NUL) begin
          emitted_count <= '0;
        end else if (emitted_count != LEN_MAX) begin
          emitted_count <= emitted_count + LEN_W'(1);
        end
      end
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      txt_valid <= 1'b0;
    end else if (emit) begin
      txt_valid <= 1'b1;
    end else if (txt_ready) begin
      txt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= emit_char;
      last_of_run <= emit_last;
      text_length <= (kind == K_NUL) ? emitted_count : '0;
    end
  end

`include "format_string_integer_printer_assert.svh"

  `FSIP_ASSERT_HOLDS(a_len_only_on_nul, clk, rst, txt_valid && (text_length != '0), (out_char == CH_NUL) && last_of_run)
  `FSIP_ASSERT_NEXT(a_nul_clears_count, clk, rst, emit && (kind == K_NUL), emitted_count == '0)
  `FSIP_ASSERT_HOLDS(a_hex_pos_range, clk, rst, (state == ST_EMIT) && (kind == K_HEX), pos < POS_W'(HEX_N))
  `FSIP_ASSERT_HOLDS(a_dec_digit_fits, clk, rst, (state == ST_EMIT) && (kind == K_DEC), WIDE_W'(val) < pow10(pos + POS_W'(1)))

endmodule

// ===== hw/rtl/format_string_integer_printer.sv =====
// Top level of the printf-style integer formatter.
//
//   channel  signals                              direction  beat
//   fmt      fmt_valid/fmt_ready, fmt_char,       in         one format byte
//            arg_value                                       with its argument
//   txt      txt_valid/txt_ready, out_char,       out        one text byte
//            last_of_run, text_length
//
// The emitter loads a command only while idle, then emits its bytes in order:
// one byte for a plain byte or NUL, two for an unknown sequence, and up to
// eleven for a negative 32-bit decimal (sign plus ten digits). A lone percent
// is taken by the front end and emits nothing.
// The front end takes a byte each cycle while the two-entry queue has room.
// A stalled txt beat holds the emitter; reset clears the pending percent, the
// count, the queue and the output beat.
`timescale 1ns / 1ps
module format_string_integer_printer #(
  parameter int ARG_WIDTH = fsip_pkg::DEFAULT_ARG_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fmt_valid,
  output logic                              fmt_ready,
  input  logic [fsip_pkg::CHAR_W-1:0]       fmt_char,
  input  logic [fsip_pkg::ARG_FIELD_W-1:0]  arg_value,
  output logic                              txt_valid,
  input  logic                              txt_ready,
  output logic [fsip_pkg::CHAR_W-1:0]       out_char,
  output logic                              last_of_run,
  output logic [fsip_pkg::LEN_W-1:0]        text_length
);
  import fsip_pkg::*;

  localparam int VAL_W = (ARG_WIDTH < ARG_FIELD_W) ? ARG_WIDTH : ARG_FIELD_W;

  logic             push;
  fsip_cmd_t        push_cmd;
  logic [VAL_W-1:0] push_val;
  logic             full;
  logic             pop;
  logic             empty;
  fsip_cmd_t        head_cmd;
  logic [VAL_W-1:0] head_val;

  fsip_front #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .fmt_valid (fmt_valid),
    .fmt_ready (fmt_ready),
    .fmt_char  (fmt_char),
    .arg_value (arg_value),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_val  (push_val)
  );

  fsip_queue #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .push_val (push_val),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head_cmd (head_cmd),
    .head_val (head_val)
  );

  fsip_back #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head_cmd    (head_cmd),
    .head_val    (head_val),
    .pop         (pop),
    .txt_valid   (txt_valid),
    .txt_ready   (txt_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .text_length (text_length)
  );

endmodule
